/* sv/bicubic_bspline_grid_evaluator_unit_defines.svh */
// Assertion macros for the bicubic B-spline grid evaluator.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef BICUBIC_BSPLINE_GRID_EVALUATOR_UNIT_DEFINES_SVH
`define BICUBIC_BSPLINE_GRID_EVALUATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BBGE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbge: same-cycle check failed");
`define BBGE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbge: next-cycle check failed");
`else
`define BBGE_ASSERT_IMP(lbl, ante, cons)
`define BBGE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/bbge_pkg.sv */
// Shared types, codes and helpers of the bicubic B-spline grid evaluator.
// No dependencies.
package bbge_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int PIDX_W    = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_U_VERTICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V_VERTICES = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET_SIDE = 7'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic signed [31:0] wgt_t;

  typedef struct packed {
    logic              op;
    logic [11:0]       point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [16:0]       u_coord;
    logic [16:0]       v_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] du_x;
    logic signed [31:0] du_y;
    logic signed [31:0] du_z;
    logic signed [31:0] dv_x;
    logic signed [31:0] dv_y;
    logic signed [31:0] dv_z;
    logic signed [63:0] normal_x;
    logic signed [63:0] normal_y;
    logic signed [63:0] normal_z;
  } out_item_t;

  typedef struct packed {
    logic       col_vld;
    logic [1:0] col_c;
    logic [1:0] col_r;
    logic       row_vld;
    logic [1:0] row_c;
    logic       scale;
  } lane_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOCATE,
    S_BASIS_V,
    S_BASIS_U,
    S_REDUCE,
    S_READ,
    S_DRAIN,
    S_ROW,
    S_SCALE,
    S_CROSS,
    S_FINISH
  } bbge_state_e;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/bbge_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module bbge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bbge_basis.sv */
// Uniform cubic B-spline basis unit: positional and derivative weights, Q.28.
// Multi-cycle; one weight per step after the numerators. Depends on bbge_pkg.
module bbge_basis
  import bbge_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] t_i,
  output logic        done_o,
  output wgt_t        w_o [4],
  output wgt_t        d_o [4]
);

  localparam logic [2:0] STEP_SQ   = 3'd0;
  localparam logic [2:0] STEP_CUBE = 3'd1;
  localparam logic [2:0] STEP_NUM  = 3'd2;
  localparam logic [2:0] STEP_W0   = 3'd3;
  localparam logic [2:0] STEP_W3   = 3'd6;
  localparam logic [63:0] RECIP6   = 64'h00000000AAAAAAAB;

  logic        busy_q, done_q;
  logic [2:0]  cnt_q;
  logic [16:0] t_q, s;
  logic [32:0] t2_q, s2_q;
  logic [49:0] t3_q, s3_q;
  logic [31:0] q_q [4];
  wgt_t        w_q [4];
  wgt_t        d_q [4];

  logic signed [39:0] t2s, s2s, ts;
  logic signed [39:0] dn [4];
  logic signed [53:0] bt3, bs3, bt2, bt;
  logic signed [53:0] nn [4];
  logic signed [53:0] qn [4];
  logic [2:0]  wi3;
  logic [1:0]  wi;
  logic [63:0] wprod;

  assign s   = 17'd65536 - t_q;
  assign t2s = $signed({7'd0, t2_q});
  assign s2s = $signed({7'd0, s2_q});
  assign ts  = $signed({23'd0, t_q});

  assign dn[0] = (40'sd16 - s2s) >>> 5;
  assign dn[1] = (40'sd3 * t2s - (ts <<< 18) + 40'sd16) >>> 5;
  assign dn[2] = (40'sd4294967296 - 40'sd3 * t2s + (ts <<< 17) + 40'sd16) >>> 5;
  assign dn[3] = (t2s + 40'sd16) >>> 5;

  assign bt3 = $signed({4'd0, t3_q});
  assign bs3 = $signed({4'd0, s3_q});
  assign bt2 = $signed({21'd0, t2_q});
  assign bt  = $signed({37'd0, t_q});

  assign nn[0] = bs3;
  assign nn[1] = 54'sd3 * bt3 - ((54'sd6 * bt2) <<< 16) + (54'sd4 <<< 48);
  assign nn[2] = (54'sd1 <<< 48) - 54'sd3 * bt3 + ((54'sd3 * bt2) <<< 16)
               + ((54'sd3 * bt) <<< 32);
  assign nn[3] = bt3;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qn[i] = (nn[i] + (54'sd3 <<< 20)) >>> 20;
    end
  end

  assign wi3   = cnt_q - STEP_W0;
  assign wi    = wi3[1:0];
  assign wprod = {32'd0, q_q[wi]} * RECIP6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= STEP_SQ;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= STEP_SQ;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 3'd1;
      done_q <= (cnt_q == STEP_W3);
      busy_q <= (cnt_q != STEP_W3);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q <= t_i;
    end else if (busy_q) begin
      case (cnt_q)
        STEP_SQ: begin
          t2_q <= 33'(t_q) * 33'(t_q);
          s2_q <= 33'(s) * 33'(s);
        end
        STEP_CUBE: begin
          t3_q <= 50'(t2_q) * 50'(t_q);
          s3_q <= 50'(s2_q) * 50'(s);
          for (int i = 0; i < 4; i++) begin
            d_q[i] <= dn[i][31:0];
          end
        end
        STEP_NUM: begin
          for (int i = 0; i < 4; i++) begin
            q_q[i] <= qn[i][31:0];
          end
        end
        default: begin
          w_q[wi] <= $signed({2'd0, wprod[63:34]});
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign w_o    = w_q;
  assign d_o    = d_q;

endmodule

/* sv/bbge_lane.sv */
// One coordinate lane: column pass over 16 control points, row pass over
// the four column sums, rounding and derivative scaling. Depends on bbge_pkg.
module bbge_lane
  import bbge_pkg::*;
#(
  parameter int SW = 7
) (
  input  logic               clk_i,
  input  lane_ctl_t          ctl_i,
  input  logic signed [31:0] pt_i,
  input  wgt_t               wv_p_i,
  input  wgt_t               wv_d_i,
  input  wgt_t               wu_p_i,
  input  wgt_t               wu_d_i,
  input  logic [SW-1:0]      nu_m3_i,
  input  logic [SW-1:0]      nv_m3_i,
  output logic signed [31:0] pos_o,
  output logic signed [31:0] du_o,
  output logic signed [31:0] dv_o
);

  logic signed [63:0] acc_p_q, acc_d_q, prod_p, prod_d, sum_p, sum_d;
  logic signed [35:0] colp_q [4];
  logic signed [35:0] cold_q [4];
  logic signed [35:0] csel_p, csel_d;
  logic signed [67:0] acc_s_q, acc_u_q, acc_v_q;
  logic signed [67:0] prod_s, prod_u, prod_v, sum_s, sum_u, sum_v;
  logic signed [39:0] rs, ru, rv;
  logic signed [63:0] mu, mv;
  logic signed [31:0] pos_q, du_q, dv_q;

  function automatic logic signed [35:0] rnd64(logic signed [63:0] v);
    logic signed [63:0] x;
    x = (v + 64'sd134217728) >>> 28;
    return x[35:0];
  endfunction

  function automatic logic signed [39:0] rnd68(logic signed [67:0] v);
    logic signed [67:0] x;
    x = (v + 68'sd134217728) >>> 28;
    return x[39:0];
  endfunction

  assign prod_p = 64'(wv_p_i) * 64'(pt_i);
  assign prod_d = 64'(wv_d_i) * 64'(pt_i);
  assign sum_p  = ((ctl_i.col_r == 2'd0) ? 64'sd0 : acc_p_q) + prod_p;
  assign sum_d  = ((ctl_i.col_r == 2'd0) ? 64'sd0 : acc_d_q) + prod_d;

  assign csel_p = colp_q[ctl_i.row_c];
  assign csel_d = cold_q[ctl_i.row_c];
  assign prod_s = 68'(wu_p_i) * 68'(csel_p);
  assign prod_u = 68'(wu_d_i) * 68'(csel_p);
  assign prod_v = 68'(wu_p_i) * 68'(csel_d);
  assign sum_s  = ((ctl_i.row_c == 2'd0) ? 68'sd0 : acc_s_q) + prod_s;
  assign sum_u  = ((ctl_i.row_c == 2'd0) ? 68'sd0 : acc_u_q) + prod_u;
  assign sum_v  = ((ctl_i.row_c == 2'd0) ? 68'sd0 : acc_v_q) + prod_v;

  assign rs = rnd68(acc_s_q);
  assign ru = rnd68(acc_u_q);
  assign rv = rnd68(acc_v_q);
  assign mu = 64'(ru) * 64'($signed({1'b0, nu_m3_i}));
  assign mv = 64'(rv) * 64'($signed({1'b0, nv_m3_i}));

  always_ff @(posedge clk_i) begin
    if (ctl_i.col_vld) begin
      acc_p_q <= sum_p;
      acc_d_q <= sum_d;
      if (ctl_i.col_r == 2'd3) begin
        colp_q[ctl_i.col_c] <= rnd64(sum_p);
        cold_q[ctl_i.col_c] <= rnd64(sum_d);
      end
    end
    if (ctl_i.row_vld) begin
      acc_s_q <= sum_s;
      acc_u_q <= sum_u;
      acc_v_q <= sum_v;
    end
    if (ctl_i.scale) begin
      pos_q <= sat32(64'(rs));
      du_q  <= sat32(mu);
      dv_q  <= sat32(mv);
    end
  end

  assign pos_o = pos_q;
  assign du_o  = du_q;
  assign dv_o  = dv_q;

endmodule

/* sv/bicubic_bspline_grid_evaluator_unit.sv */
// Uniform bicubic B-spline surface evaluator over a stored control grid.
// Depends on bbge_pkg, bbge_ram, bbge_basis, bbge_lane and the defines header.
//
// Input channel (in_valid_i / in_stall_o, in_item_i): an item with op load
// writes one control point and gives no result; loads may follow each other
// in every cycle while no evaluation is in progress. An item with op evaluate
// gives one result on the output channel (out_valid_o / out_stall_i,
// out_item_o), formed in turn by two passes of the multi-cycle basis unit, a
// reciprocal reduction of the grid address modulo STORE_DEPTH, sixteen reads
// from the single point memory port, a four-step row pass, scaling and the
// cross product. One evaluation is worked on at a time; in_stall_o is high
// until it reaches the output register, so no new item is taken before then.
// The output register holds a result while out_stall_i is high; meanwhile
// loads and the next evaluation proceed, which waits at its end if the
// register is still full.
// Configuration (cfg_valid_i / cfg_ready_o) writes u_vertices (index 0) or
// v_vertices (index 1); other indices are dropped. Write only when idle.
// Reset returns both sides to 4 and empties the output register; the point
// memory is not cleared and holds arbitrary data until loaded.
`include "bicubic_bspline_grid_evaluator_unit_defines.svh"
module bicubic_bspline_grid_evaluator_unit
  import bbge_pkg::*;
#(
  parameter int MAX_GRID_SIDE = 64,
  parameter int STORE_DEPTH   = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int SW = $clog2(MAX_GRID_SIDE + 1);
  localparam int EW = (SW > CFG_W) ? SW : CFG_W;
  localparam int AW = 2 * SW + 1;
  localparam int DW = $clog2(STORE_DEPTH);
  localparam int IW = (DW > PIDX_W) ? DW : PIDX_W;
  localparam int QK = AW + DW;
  localparam int QW = 2 * AW + 2;
  localparam int XW = AW + DW;
  localparam longint RECIP_L = ((64'sd1 <<< QK) + longint'(STORE_DEPTH) - 64'sd1)
                               / longint'(STORE_DEPTH);
  localparam logic [AW+1:0] RECIP = (AW+2)'(RECIP_L);

  bbge_state_e state_q, state_d;

  logic [CFG_W-1:0] u_vert_q, v_vert_q;
  logic [EW-1:0]    u_ext, v_ext;
  logic [SW-1:0]    nu, nv, nu_m3, nv_m3, nu_m4, nv_m4;

  logic in_acc, is_eval;
  logic [16:0] coord_u_q, coord_v_q;
  logic [SW+16:0] loc_u, loc_v;
  logic [SW-1:0]  cx_q, cy_q;
  logic [16:0]    tu_q;

  logic        bas_start, bas_done;
  logic [16:0] bas_t;
  wgt_t        bas_w [4];
  wgt_t        bas_d [4];
  wgt_t        bv_q [4];
  wgt_t        dv_q [4];
  wgt_t        bu_q [4];
  wgt_t        du_q [4];

  logic [AW-1:0] red_a_q, red_n_q, quo_a_q, quo_n_q;
  logic [QW-1:0] qprod_a, qprod_n;
  logic [XW-1:0] rem_a, rem_n;
  logic          red_ph_q;

  logic [DW-1:0] addr_q, col_q, num_q, col_next;
  logic [3:0]    idx_q, rd_idx_q;
  logic          rd_vld_q, rd_en;
  logic [1:0]    row_q;

  logic          we;
  logic [IW-1:0] widx;
  logic [95:0]   rd_data;

  lane_ctl_t          lane_ctl;
  logic signed [31:0] l_pos [3];
  logic signed [31:0] l_du [3];
  logic signed [31:0] l_dv [3];
  logic signed [63:0] xp_q [6];

  logic      out_valid_q, out_load;
  out_item_t out_item_q;

  function automatic logic [SW+16:0] locate_f(logic [16:0] coord, logic [SW-1:0] m3,
                                              logic [SW-1:0] m4);
    logic [16:0]    c;
    logic [SW+16:0] p, f;
    logic [SW:0]    k;
    c = (coord > 17'd65536) ? 17'd65536 : coord;
    p = (SW+17)'(c) * (SW+17)'(m3);
    k = p[SW+16:16];
    if (k > {1'b0, m4}) begin
      k = {1'b0, m4};
    end
    f = p - ((SW+17)'(k) << 16);
    return {k[SW-1:0], f[16:0]};
  endfunction

  function automatic logic [DW-1:0] mod_add(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW:0] x;
    x = {1'b0, a} + {1'b0, b};
    if (x >= (DW+1)'(STORE_DEPTH)) begin
      x = x - (DW+1)'(STORE_DEPTH);
    end
    return x[DW-1:0];
  endfunction

  function automatic logic signed [63:0] sat64(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] x;
    logic signed [63:0] r;
    x = 65'(a) - 65'(b);
    if (x[64] != x[63]) begin
      r = x[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    end else begin
      r = x[63:0];
    end
    return r;
  endfunction

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_vert_q <= CFG_RESET_SIDE;
      v_vert_q <= CFG_RESET_SIDE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_U_VERTICES: u_vert_q <= cfg_data_i;
        CFG_V_VERTICES: v_vert_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign u_ext = EW'(u_vert_q);
  assign v_ext = EW'(v_vert_q);

  always_comb begin
    if (u_ext < EW'(4)) begin
      nu = SW'(4);
    end else if (u_ext > EW'(MAX_GRID_SIDE)) begin
      nu = SW'(MAX_GRID_SIDE);
    end else begin
      nu = u_ext[SW-1:0];
    end
    if (v_ext < EW'(4)) begin
      nv = SW'(4);
    end else if (v_ext > EW'(MAX_GRID_SIDE)) begin
      nv = SW'(MAX_GRID_SIDE);
    end else begin
      nv = v_ext[SW-1:0];
    end
  end

  assign nu_m3 = nu - SW'(3);
  assign nv_m3 = nv - SW'(3);
  assign nu_m4 = nu - SW'(4);
  assign nv_m4 = nv - SW'(4);

  // input side and point memory
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_eval    = (in_item_i.op == OP_EVAL);
  assign widx       = IW'(in_item_i.point_index);
  assign we         = in_acc && (in_item_i.op == OP_LOAD)
                      && (32'(in_item_i.point_index) < 32'(STORE_DEPTH));

  bbge_ram #(
    .WIDTH(96),
    .DEPTH(STORE_DEPTH)
  ) u_points (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(widx[DW-1:0]),
    .wdata_i({in_item_i.point_z, in_item_i.point_y, in_item_i.point_x}),
    .re_i   (rd_en),
    .raddr_i(addr_q),
    .rdata_o(rd_data)
  );

  assign loc_u = locate_f(coord_u_q, nu_m3, nu_m4);
  assign loc_v = locate_f(coord_v_q, nv_m3, nv_m4);

  bbge_basis u_basis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(bas_start),
    .t_i    (bas_t),
    .done_o (bas_done),
    .w_o    (bas_w),
    .d_o    (bas_d)
  );

  assign qprod_a  = QW'(red_a_q) * QW'(RECIP);
  assign qprod_n  = QW'(red_n_q) * QW'(RECIP);
  assign rem_a    = XW'(red_a_q) - XW'(quo_a_q) * XW'(STORE_DEPTH);
  assign rem_n    = XW'(red_n_q) - XW'(quo_n_q) * XW'(STORE_DEPTH);
  assign col_next = mod_add(col_q, DW'(1));

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc && is_eval) state_d = S_LOCATE;
      S_LOCATE:  state_d = S_BASIS_V;
      S_BASIS_V: if (bas_done) state_d = S_BASIS_U;
      S_BASIS_U: if (bas_done) state_d = S_REDUCE;
      S_REDUCE:  if (red_ph_q) state_d = S_READ;
      S_READ:    if (idx_q == 4'd15) state_d = S_DRAIN;
      S_DRAIN:   state_d = S_ROW;
      S_ROW:     if (row_q == 2'd3) state_d = S_SCALE;
      S_SCALE:   state_d = S_CROSS;
      S_CROSS:   state_d = S_FINISH;
      S_FINISH:  if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    bas_start = 1'b0;
    bas_t     = tu_q;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    lane_ctl  = '0;
    lane_ctl.col_vld = rd_vld_q;
    lane_ctl.col_c   = rd_idx_q[3:2];
    lane_ctl.col_r   = rd_idx_q[1:0];
    lane_ctl.row_c   = row_q;
    unique case (state_q)
      S_LOCATE: begin
        bas_start = 1'b1;
        bas_t     = loc_v[16:0];
      end
      S_BASIS_V: bas_start = bas_done;
      S_READ:    rd_en = 1'b1;
      S_ROW:     lane_ctl.row_vld = 1'b1;
      S_SCALE:   lane_ctl.scale = 1'b1;
      S_FINISH:  out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_vld_q <= 1'b0;
      idx_q    <= '0;
      row_q    <= '0;
      red_ph_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      unique case (state_q)
        S_BASIS_U: if (bas_done) red_ph_q <= 1'b0;
        S_REDUCE: begin
          red_ph_q <= 1'b1;
          idx_q    <= '0;
        end
        S_READ:  idx_q <= idx_q + 4'd1;
        S_DRAIN: row_q <= '0;
        S_ROW:   row_q <= row_q + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (in_acc) begin
      coord_u_q <= in_item_i.u_coord;
      coord_v_q <= in_item_i.v_coord;
    end
    unique case (state_q)
      S_LOCATE: begin
        cx_q <= loc_u[SW+16:17];
        cy_q <= loc_v[SW+16:17];
        tu_q <= loc_u[16:0];
      end
      S_BASIS_V: if (bas_done) begin
        bv_q <= bas_w;
        dv_q <= bas_d;
      end
      S_BASIS_U: if (bas_done) begin
        bu_q    <= bas_w;
        du_q    <= bas_d;
        red_a_q <= AW'(cy_q) * AW'(nu) + AW'(cx_q);
        red_n_q <= AW'(nu);
      end
      S_REDUCE: begin
        quo_a_q <= AW'(qprod_a >> QK);
        quo_n_q <= AW'(qprod_n >> QK);
        addr_q  <= rem_a[DW-1:0];
        col_q   <= rem_a[DW-1:0];
        num_q   <= rem_n[DW-1:0];
      end
      S_READ: begin
        if (idx_q[1:0] == 2'd3) begin
          col_q  <= col_next;
          addr_q <= col_next;
        end else begin
          addr_q <= mod_add(addr_q, num_q);
        end
      end
      S_CROSS: begin
        xp_q[0] <= 64'(l_du[1]) * 64'(l_dv[2]);
        xp_q[1] <= 64'(l_du[2]) * 64'(l_dv[1]);
        xp_q[2] <= 64'(l_du[2]) * 64'(l_dv[0]);
        xp_q[3] <= 64'(l_du[0]) * 64'(l_dv[2]);
        xp_q[4] <= 64'(l_du[0]) * 64'(l_dv[1]);
        xp_q[5] <= 64'(l_du[1]) * 64'(l_dv[0]);
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    bbge_lane #(
      .SW(SW)
    ) u_lane (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .pt_i   ($signed(rd_data[32*g +: 32])),
      .wv_p_i (bv_q[rd_idx_q[1:0]]),
      .wv_d_i (dv_q[rd_idx_q[1:0]]),
      .wu_p_i (bu_q[row_q]),
      .wu_d_i (du_q[row_q]),
      .nu_m3_i(nu_m3),
      .nv_m3_i(nv_m3),
      .pos_o  (l_pos[g]),
      .du_o   (l_du[g]),
      .dv_o   (l_dv[g])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.pos_x    <= l_pos[0];
      out_item_q.pos_y    <= l_pos[1];
      out_item_q.pos_z    <= l_pos[2];
      out_item_q.du_x     <= l_du[0];
      out_item_q.du_y     <= l_du[1];
      out_item_q.du_z     <= l_du[2];
      out_item_q.dv_x     <= l_dv[0];
      out_item_q.dv_y     <= l_dv[1];
      out_item_q.dv_z     <= l_dv[2];
      out_item_q.normal_x <= sat64(xp_q[0], xp_q[1]);
      out_item_q.normal_y <= sat64(xp_q[2], xp_q[3]);
      out_item_q.normal_z <= sat64(xp_q[4], xp_q[5]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `BBGE_ASSERT_IMP(a_rd_in_range, rd_en, 32'(addr_q) < 32'(STORE_DEPTH))
  `BBGE_ASSERT_IMP(a_no_overwrite, out_load, !(out_valid_q && out_stall_i))
  `BBGE_ASSERT_IMP(a_basis_expected, bas_done, state_q == S_BASIS_V || state_q == S_BASIS_U)
  `BBGE_ASSERT_NEXT(a_last_read, rd_en && idx_q == 4'd15, rd_vld_q && rd_idx_q == 4'd15)

endmodule

/* bench/bicubic_bspline_grid_evaluator_unit_test.sv */
// Self-checking bench for the bicubic B-spline grid evaluator: random loads and
// evaluations through several grid shapes, checked against an in-bench surface model.
// Depends on bbge_pkg and the bicubic_bspline_grid_evaluator_unit top level.
module bicubic_bspline_grid_evaluator_unit_test;
  import bbge_pkg::*;

  localparam int STORE_SLOTS = 4096;
  localparam int GRID_MAX    = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  bicubic_bspline_grid_evaluator_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t              pending_items[$];
  out_item_t             surface_q[$];
  logic signed [31:0]    grid_pts[3][STORE_SLOTS];
  bit                    slot_loaded[STORE_SLOTS];
  logic [CFG_W-1:0]      u_side_reg = CFG_RESET_SIDE;
  logic [CFG_W-1:0]      v_side_reg = CFG_RESET_SIDE;
  int                    mismatches = 0;
  int                    cycles = 0;
  bit                    quiet = 1'b0;
  bit                    hold_req = 1'b0;
  logic                  in_fire = 1'b0;
  int                    send_gap = 0;
  int                    recv_gap = 0;
  int                    hold_left = 0;

  function automatic int grid_side(logic [CFG_W-1:0] n);
    if (n < 4) return 4;
    if (n > GRID_MAX) return GRID_MAX;
    return int'(n);
  endfunction

  function automatic longint round_q(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void find_patch(logic [16:0] coord, int n, output int patch,
                                     output longint frac);
    longint c, p;
    c = (coord > 17'd65536) ? 65536 : longint'(coord);
    p = c * (n - 3);
    patch = int'(p >>> 16);
    if (patch > n - 4) patch = n - 4;
    frac = p - (longint'(patch) <<< 16);
  endfunction

  function automatic void weights(longint t, output longint w[4], output longint d[4]);
    longint s, t2, t3, den;
    longint n[4];
    s = 65536 - t;
    t2 = t * t;
    t3 = t2 * t;
    den = 6 * (64'sd1 <<< 20);
    n[0] = s * s * s;
    n[1] = 3 * t3 - 6 * t2 * 65536 + 4 * (64'sd1 <<< 48);
    n[2] = -3 * t3 + 3 * t2 * 65536 + 3 * t * (64'sd1 <<< 32) + (64'sd1 <<< 48);
    n[3] = t3;
    for (int i = 0; i < 4; i++) w[i] = (n[i] + den / 2) / den;
    d[0] = round_q(-(s * s), 5);
    d[1] = round_q(3 * t2 - 4 * t * 65536, 5);
    d[2] = round_q(-3 * t2 + 2 * t * 65536 + (64'sd1 <<< 32), 5);
    d[3] = round_q(t2, 5);
  endfunction

  function automatic longint cross_sat(longint a, longint b, longint c, longint d);
    longint p1, p2;
    p1 = a * b;
    p2 = c * d;
    if (p2 < 0 && p1 > 64'sh7FFFFFFFFFFFFFFF + p2) return 64'sh7FFFFFFFFFFFFFFF;
    if (p2 > 0 && p1 < 64'sh8000000000000000 + p2) return 64'sh8000000000000000;
    return p1 - p2;
  endfunction

  function automatic out_item_t surface_at(in_item_t it);
    int nu, nv, cx, cy, a;
    longint tu, tv, ap, ad, sp, su, sv;
    longint bu[4], du[4], bv[4], dv[4], colp[4], cold[4];
    longint pos[3], dpu[3], dpv[3];
    out_item_t r;
    nu = grid_side(u_side_reg);
    nv = grid_side(v_side_reg);
    find_patch(it.u_coord, nu, cx, tu);
    find_patch(it.v_coord, nv, cy, tv);
    weights(tu, bu, du);
    weights(tv, bv, dv);
    for (int j = 0; j < 3; j++) begin
      for (int c = 0; c < 4; c++) begin
        ap = 0;
        ad = 0;
        for (int k = 0; k < 4; k++) begin
          a = ((cy + k) * nu + cx + c) % STORE_SLOTS;
          ap += bv[k] * longint'(grid_pts[j][a]);
          ad += dv[k] * longint'(grid_pts[j][a]);
        end
        colp[c] = round_q(ap, 28);
        cold[c] = round_q(ad, 28);
      end
      sp = 0;
      su = 0;
      sv = 0;
      for (int c = 0; c < 4; c++) begin
        sp += bu[c] * colp[c];
        su += du[c] * colp[c];
        sv += bu[c] * cold[c];
      end
      pos[j] = clamp32(round_q(sp, 28));
      dpu[j] = clamp32(round_q(su, 28) * (nu - 3));
      dpv[j] = clamp32(round_q(sv, 28) * (nv - 3));
    end
    r.pos_x = pos[0][31:0];
    r.pos_y = pos[1][31:0];
    r.pos_z = pos[2][31:0];
    r.du_x = dpu[0][31:0];
    r.du_y = dpu[1][31:0];
    r.du_z = dpu[2][31:0];
    r.dv_x = dpv[0][31:0];
    r.dv_y = dpv[1][31:0];
    r.dv_z = dpv[2][31:0];
    r.normal_x = cross_sat(dpu[1], dpv[2], dpu[2], dpv[1]);
    r.normal_y = cross_sat(dpu[2], dpv[0], dpu[0], dpv[2]);
    r.normal_z = cross_sat(dpu[0], dpv[1], dpu[1], dpv[0]);
    return r;
  endfunction

  function automatic void split_fields(out_item_t r, output longint f[12]);
    f = '{longint'(r.pos_x), longint'(r.pos_y), longint'(r.pos_z),
          longint'(r.du_x), longint'(r.du_y), longint'(r.du_z),
          longint'(r.dv_x), longint'(r.dv_y), longint'(r.dv_z),
          r.normal_x, r.normal_y, r.normal_z};
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0d: %s got %0d want %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // Stimulus generation
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic push_load(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.point_index = slot[11:0];
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.u_coord = 17'($urandom());
    it.v_coord = 17'($urandom());
    slot_loaded[slot] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic push_eval(logic [16:0] u, logic [16:0] v);
    in_item_t it;
    int nu, cx, cy, a;
    longint f;
    nu = grid_side(u_side_reg);
    find_patch(u, nu, cx, f);
    find_patch(v, grid_side(v_side_reg), cy, f);
    for (int k = 0; k < 4; k++)
      for (int c = 0; c < 4; c++) begin
        a = ((cy + k) * nu + cx + c) % STORE_SLOTS;
        if (!slot_loaded[a]) push_load(a, rand_coord(), rand_coord(), rand_coord());
      end
    it.op = OP_EVAL;
    it.point_index = 12'($urandom());
    it.point_x = $urandom();
    it.point_y = $urandom();
    it.point_z = $urandom();
    it.u_coord = u;
    it.v_coord = v;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_items.size() != 0 || in_valid_i || surface_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_U_VERTICES) u_side_reg = val;
    else if (idx == CFG_V_VERTICES) v_side_reg = val;
  endtask

  task automatic set_grid(logic [CFG_W-1:0] nu, logic [CFG_W-1:0] nv);
    cfg_write(CFG_U_VERTICES, nu);
    cfg_write(CFG_V_VERTICES, nv);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_phase(int count);
    int nu, nv;
    nu = grid_side(u_side_reg);
    nv = grid_side(v_side_reg);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 4)
        push_load($urandom_range(0, STORE_SLOTS - 1) % (nu * nv),
                  rand_coord(), rand_coord(), rand_coord());
      else
        push_eval(rand_param(), rand_param());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] shapes[8][2];
    shapes = '{'{7'd64, 7'd64}, '{7'd0, 7'd127}, '{7'd127, 7'd3}, '{7'd5, 7'd9},
               '{7'd17, 7'd4}, '{7'd4, 7'd64}, '{7'd33, 7'd21}, '{7'd6, 7'd6}};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cfg_write(CFG_SPARE_A, 7'd50);
    cfg_write(CFG_SPARE_B, 7'd9);
    set_grid(7'd4, 7'd4);
    for (int s = 0; s < 16; s++)
      push_load(s, (s % 4 == 0) ? 32'h7FFFFFFF : 32'h80000000,
                (s % 2 == 0) ? 32'h80000000 : 32'h7FFFFFFF,
                (s < 8) ? 32'h0 : 32'hFFFFFFFF);
    push_eval(17'd0, 17'd0);
    push_eval(17'd65536, 17'd65536);
    push_eval(17'd131071, 17'd0);
    push_eval(17'd32768, 17'd65537);
    push_eval(17'd1, 17'd65535);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_grid(p == 7 ? 7'($urandom_range(0, 127)) : shapes[p][0],
               p == 7 ? 7'($urandom_range(0, 127)) : shapes[p][1]);
      if (p == 1) hold_req = 1'b1;
      if (p == 7) quiet = 1'b1;
      random_phase(p == 0 ? 40 : 120);
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Input side: offer items, idle in bursts
  always @(posedge clk_i) in_fire <= in_valid_i && !in_stall_o;

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 7);
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: stall in bursts, plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Track accepted items and work out expected surfaces
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (in_item_i.op == OP_LOAD) begin
        grid_pts[0][in_item_i.point_index] = in_item_i.point_x;
        grid_pts[1][in_item_i.point_index] = in_item_i.point_y;
        grid_pts[2][in_item_i.point_index] = in_item_i.point_z;
      end else begin
        surface_q.push_back(surface_at(in_item_i));
      end
    end
  end

  always @(posedge clk_i) begin
    longint got[12], want[12];
    string names[12];
    names = '{"pos_x", "pos_y", "pos_z", "du_x", "du_y", "du_z",
              "dv_x", "dv_y", "dv_z", "normal_x", "normal_y", "normal_z"};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (surface_q.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        split_fields(out_item_o, got);
        split_fields(surface_q.pop_front(), want);
        for (int i = 0; i < 12; i++)
          if (got[i] !== want[i]) report(names[i], got[i], want[i]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
